>>> sv/dtl_pkg.sv
// ----------------------------------------------------------------------------
// Datalog token lexer package
// Shared types, widths and token codes for the lexer front, queue and back.
// ----------------------------------------------------------------------------
package dtl_pkg;

	localparam int LINE_WIDTH       = 16;
	localparam int MAX_TOKEN_LENGTH = 65535;
	localparam int LEN_W            = 16;
	localparam int OUT_LINE_W       = 16;
	localparam int KIND_W           = 5;
	localparam int CHAR_W           = 8;
	localparam int DATA_W           = 40;
	localparam int QUEUE_DEPTH      = 4;
	localparam int QPTR_W           = $clog2(QUEUE_DEPTH);

	typedef logic [LINE_WIDTH-1:0] line_t;
	typedef logic [LEN_W-1:0]      len_t;
	typedef logic [CHAR_W-1:0]     char_t;

	typedef enum logic [KIND_W-1:0] {
		K_COMMA     = 5'd0,
		K_PERIOD    = 5'd1,
		K_QMARK     = 5'd2,
		K_LPAREN    = 5'd3,
		K_RPAREN    = 5'd4,
		K_COLON     = 5'd5,
		K_COLONDASH = 5'd6,
		K_MUL       = 5'd7,
		K_ADD       = 5'd8,
		K_SCHEMES   = 5'd9,
		K_FACTS     = 5'd10,
		K_RULES     = 5'd11,
		K_QUERIES   = 5'd12,
		K_ID        = 5'd13,
		K_STRING    = 5'd14,
		K_COMMENT   = 5'd15,
		K_UNDEF     = 5'd16,
		K_END       = 5'd17
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [OUT_LINE_W-1:0] line;
		len_t                  len;
	} tok_t;

	typedef struct packed {
		tok_t tok0;
		tok_t tok1;
		logic two;
	} pair_t;

endpackage

>>> sv/datalog_token_lexer_unit.sv
// ----------------------------------------------------------------------------
// Datalog token lexer
// Turns a byte stream of Datalog-like source text into a token stream.
//
// The slave stream carries one character per transfer in s_axis_tdata; a
// transfer with s_axis_tlast high marks the end of the text, its data is
// ignored, any open token is flushed and an END token follows. The master
// stream carries one token per transfer; m_axis_tlast marks the last token
// caused by one input character. The cfg channel sets keep_comments, and is
// always ready.
// One character is accepted per cycle while the queue has room. Each token
// passes through the queue and then the output register. A character that
// yields two tokens sends them one after the other through the single output
// register; a four-entry queue between the lexer front and the output
// absorbs such bursts, and s_axis_tready drops only when it is full.
// When the receiver stalls, the output holds and the queue fills.
// Reset clears the lexer to line one, the queue, and keep_comments to zero.
// ----------------------------------------------------------------------------
module datalog_token_lexer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [4:0] token_kind, [20:5] start_line,
	                                    // [36:21] text_length, [39:37] zero
	output logic        m_axis_tlast
);
	import dtl_pkg::*;

	logic  q_full;
	logic  q_push;
	pair_t q_wdata;
	logic  q_valid;
	logic  q_pop;
	pair_t q_rdata;
	tok_t  out_tok;

	dtl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_char   (s_axis_tdata),
		.in_end    (s_axis_tlast),
		.q_full    (q_full),
		.push      (q_push),
		.push_data (q_wdata)
	);

	dtl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_rdata)
	);

	dtl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_tok   (out_tok),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {3'b000, out_tok.len, out_tok.line, out_tok.kind};

endmodule

>>> sv/dtl_front.sv
// ----------------------------------------------------------------------------
// Datalog token lexer front
// Runs the lexer mode machine on one character per cycle while the queue has
// room, and queues the zero, one or two tokens that each character produces.
// ----------------------------------------------------------------------------
module dtl_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_data,
	input  logic          in_valid,
	output logic          in_ready,
	input  dtl_pkg::char_t in_char,
	input  logic          in_end,
	input  logic          q_full,
	output logic          push,
	output dtl_pkg::pair_t push_data
);
	import dtl_pkg::*;

	typedef enum logic [2:0] {
		M_IDLE,
		M_ID,
		M_COLON,
		M_STRING,
		M_HASH,
		M_LINE,
		M_BLOCK
	} mode_t;

	localparam char_t CH_NL     = 8'h0A;
	localparam char_t CH_SPACE  = 8'h20;
	localparam char_t CH_TAB    = 8'h09;
	localparam char_t CH_CR     = 8'h0D;
	localparam char_t CH_COMMA  = 8'h2C;
	localparam char_t CH_PERIOD = 8'h2E;
	localparam char_t CH_QMARK  = 8'h3F;
	localparam char_t CH_LPAREN = 8'h28;
	localparam char_t CH_RPAREN = 8'h29;
	localparam char_t CH_MUL    = 8'h2A;
	localparam char_t CH_ADD    = 8'h2B;
	localparam char_t CH_COLON  = 8'h3A;
	localparam char_t CH_DASH   = 8'h2D;
	localparam char_t CH_QUOTE  = 8'h27;
	localparam char_t CH_HASH   = 8'h23;
	localparam char_t CH_BAR    = 8'h7C;
	localparam line_t LINE_MAX  = '1;
	localparam len_t  LEN_MAX   = len_t'(MAX_TOKEN_LENGTH);

	function automatic logic [OUT_LINE_W-1:0] out_line(input line_t l);
		logic [32:0] w;
		w = 33'(l);
		return (w > 33'(17'h0FFFF)) ? '1 : w[OUT_LINE_W-1:0];
	endfunction

	function automatic len_t kw_len(input logic [1:0] k);
		return (k == 2'd1 || k == 2'd2) ? len_t'(5) : len_t'(7);
	endfunction

	function automatic char_t kw_char(input logic [1:0] k, input logic [2:0] p);
		logic [63:0] w;
		case (k)
			2'd0:    w = "Schemes ";
			2'd1:    w = "Facts   ";
			2'd2:    w = "Rules   ";
			default: w = "Queries ";
		endcase
		return w[{~p, 3'b000} +: 8];
	endfunction

	function automatic tok_t mk_tok(input kind_t k, input line_t l, input len_t n);
		tok_t t;
		t.kind = k;
		t.line = out_line(l);
		t.len  = n;
		return t;
	endfunction

	mode_t mode_q;
	line_t line_q;
	line_t start_q;
	len_t  len_q;
	logic [3:0] cand_q;
	logic  look_q;
	logic  keep_q;

	mode_t mode_n;
	line_t line_n;
	line_t start_n;
	len_t  len_n;
	logic [3:0] cand_n;
	logic  look_n;

	logic  accept;
	logic  a_v;
	logic  b_v;
	tok_t  tok_a;
	tok_t  tok_b;
	logic  do_begin;
	logic  is_nl;
	logic  is_space;
	logic  is_alpha;
	logic  is_alnum;
	len_t  len_grow;
	line_t line_inc;
	logic [3:0] hit_cont;
	logic [3:0] hit_first;
	kind_t id_kind;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;

	always_comb begin
		is_nl    = (in_char == CH_NL);
		is_space = (in_char == CH_SPACE) || (in_char >= CH_TAB && in_char <= CH_CR);
		is_alpha = (in_char >= "a" && in_char <= "z") || (in_char >= "A" && in_char <= "Z");
		is_alnum = is_alpha || (in_char >= "0" && in_char <= "9");
		len_grow = (len_q < LEN_MAX) ? len_q + len_t'(1) : len_q;
		line_inc = (line_q < LINE_MAX) ? line_q + line_t'(1) : line_q;
		for (int k = 0; k < 4; k++) begin
			hit_cont[k]  = (len_q < kw_len(2'(k))) && (kw_char(2'(k), len_q[2:0]) == in_char);
			hit_first[k] = (kw_char(2'(k), 3'd0) == in_char);
		end
		if (cand_q[0] && len_q == kw_len(2'd0)) begin
			id_kind = K_SCHEMES;
		end else if (cand_q[1] && len_q == kw_len(2'd1)) begin
			id_kind = K_FACTS;
		end else if (cand_q[2] && len_q == kw_len(2'd2)) begin
			id_kind = K_RULES;
		end else if (cand_q[3] && len_q == kw_len(2'd3)) begin
			id_kind = K_QUERIES;
		end else begin
			id_kind = K_ID;
		end
	end

	always_comb begin
		mode_n   = mode_q;
		line_n   = line_q;
		start_n  = start_q;
		len_n    = len_q;
		cand_n   = cand_q;
		look_n   = look_q;
		a_v      = 1'b0;
		b_v      = 1'b0;
		tok_a    = mk_tok(K_UNDEF, start_q, len_q);
		tok_b    = mk_tok(K_END, line_q, '0);
		do_begin = 1'b0;

		if (in_end) begin
			a_v = 1'b1;
			unique case (mode_q)
				M_ID:     tok_a = mk_tok(id_kind, start_q, len_q);
				M_COLON:  tok_a = mk_tok(K_COLON, start_q, len_t'(1));
				M_STRING: tok_a = mk_tok(look_q ? K_STRING : K_UNDEF, start_q, len_q);
				M_HASH, M_LINE: begin
					a_v   = keep_q;
					tok_a = mk_tok(K_COMMENT, start_q, len_q);
				end
				M_BLOCK:  tok_a = mk_tok(K_UNDEF, start_q, len_q);
				default:  a_v = 1'b0;
			endcase
			b_v     = 1'b1;
			mode_n  = M_IDLE;
			line_n  = line_t'(1);
			start_n = line_t'(1);
			len_n   = '0;
			cand_n  = '1;
			look_n  = 1'b0;
		end else begin
			unique case (mode_q)
				M_ID: begin
					if (is_alnum) begin
						cand_n = cand_q & hit_cont;
						len_n  = len_grow;
					end else begin
						a_v      = 1'b1;
						tok_a    = mk_tok(id_kind, start_q, len_q);
						do_begin = 1'b1;
					end
				end
				M_COLON: begin
					a_v = 1'b1;
					if (in_char == CH_DASH) begin
						tok_a  = mk_tok(K_COLONDASH, start_q, len_t'(2));
						mode_n = M_IDLE;
					end else begin
						tok_a    = mk_tok(K_COLON, start_q, len_t'(1));
						do_begin = 1'b1;
					end
				end
				M_STRING: begin
					if (look_q) begin
						look_n = 1'b0;
						if (in_char == CH_QUOTE) begin
							len_n = len_grow;
						end else begin
							a_v      = 1'b1;
							tok_a    = mk_tok(K_STRING, start_q, len_q);
							do_begin = 1'b1;
						end
					end else begin
						len_n = len_grow;
						if (is_nl) begin
							line_n = line_inc;
						end
						look_n = (in_char == CH_QUOTE);
					end
				end
				M_HASH: begin
					if (in_char == CH_BAR) begin
						len_n  = len_grow;
						look_n = 1'b0;
						mode_n = M_BLOCK;
					end else if (is_nl) begin
						a_v    = keep_q;
						tok_a  = mk_tok(K_COMMENT, start_q, len_q);
						line_n = line_inc;
						mode_n = M_IDLE;
					end else begin
						len_n  = len_grow;
						mode_n = M_LINE;
					end
				end
				M_LINE: begin
					if (is_nl) begin
						a_v    = keep_q;
						tok_a  = mk_tok(K_COMMENT, start_q, len_q);
						line_n = line_inc;
						mode_n = M_IDLE;
					end else begin
						len_n = len_grow;
					end
				end
				M_BLOCK: begin
					len_n = len_grow;
					if (is_nl) begin
						line_n = line_inc;
					end
					if (look_q && in_char == CH_HASH) begin
						a_v    = keep_q;
						tok_a  = mk_tok(K_COMMENT, start_q, len_grow);
						look_n = 1'b0;
						mode_n = M_IDLE;
					end else begin
						look_n = (in_char == CH_BAR);
					end
				end
				default: do_begin = 1'b1;
			endcase

			if (do_begin) begin
				mode_n = M_IDLE;
				b_v    = 1'b1;
				tok_b  = mk_tok(K_UNDEF, line_q, len_t'(1));
				if (is_space) begin
					b_v = 1'b0;
					if (is_nl) begin
						line_n = line_inc;
					end
				end else begin
					case (in_char)
						CH_COMMA:  tok_b.kind = K_COMMA;
						CH_PERIOD: tok_b.kind = K_PERIOD;
						CH_QMARK:  tok_b.kind = K_QMARK;
						CH_LPAREN: tok_b.kind = K_LPAREN;
						CH_RPAREN: tok_b.kind = K_RPAREN;
						CH_MUL:    tok_b.kind = K_MUL;
						CH_ADD:    tok_b.kind = K_ADD;
						CH_COLON, CH_QUOTE, CH_HASH: begin
							b_v     = 1'b0;
							start_n = line_q;
							len_n   = len_t'(1);
							look_n  = 1'b0;
							if (in_char == CH_COLON) begin
								mode_n = M_COLON;
							end else if (in_char == CH_QUOTE) begin
								mode_n = M_STRING;
							end else begin
								mode_n = M_HASH;
							end
						end
						default: begin
							if (is_alpha) begin
								b_v     = 1'b0;
								start_n = line_q;
								len_n   = len_t'(1);
								cand_n  = hit_first;
								mode_n  = M_ID;
							end
						end
					endcase
				end
			end
		end
	end

	always_comb begin
		push           = accept && (a_v || b_v);
		push_data.tok0 = a_v ? tok_a : tok_b;
		push_data.tok1 = tok_b;
		push_data.two  = a_v && b_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			line_q  <= line_t'(1);
			start_q <= line_t'(1);
			len_q   <= '0;
			cand_q  <= '1;
			look_q  <= 1'b0;
			keep_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				keep_q <= cfg_data;
			end
			if (accept) begin
				mode_q  <= mode_n;
				line_q  <= line_n;
				start_q <= start_n;
				len_q   <= len_n;
				cand_q  <= cand_n;
				look_q  <= look_n;
			end
		end
	end

endmodule

>>> sv/dtl_queue.sv
// ----------------------------------------------------------------------------
// Datalog token lexer queue
// Short register queue of token pairs between the lexer front and back.
// ----------------------------------------------------------------------------
module dtl_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dtl_pkg::pair_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output dtl_pkg::pair_t pop_data
);
	import dtl_pkg::*;

	pair_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full     = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign valid    = (cnt_q != '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> sv/dtl_back.sv
// ----------------------------------------------------------------------------
// Datalog token lexer back
// Splits queued token pairs into single transfers and holds the output
// register that the receiver drains.
// ----------------------------------------------------------------------------
module dtl_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  dtl_pkg::pair_t q_data,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output dtl_pkg::tok_t  out_tok,
	output logic           out_last
);
	import dtl_pkg::*;

	logic out_valid_q;
	logic pend_valid_q;
	tok_t pend_q;
	tok_t out_tok_q;
	logic out_last_q;
	logic load;

	assign load      = !out_valid_q || out_ready;
	assign q_pop     = load && !pend_valid_q && q_valid;
	assign out_valid = out_valid_q;
	assign out_tok   = out_tok_q;
	assign out_last  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (load) begin
			if (pend_valid_q) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (q_valid) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= q_data.two;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_valid_q) begin
				out_tok_q  <= pend_q;
				out_last_q <= 1'b1;
			end else begin
				out_tok_q  <= q_data.tok0;
				out_last_q <= !q_data.two;
				pend_q     <= q_data.tok1;
			end
		end
	end

endmodule

>>> sv/dtl_checker.sv
// ----------------------------------------------------------------------------
// Datalog token lexer checker
// Port-level assertions on the token stream, bound to the top level.
// ----------------------------------------------------------------------------
module dtl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic        cfg_data,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tlast
);
	import dtl_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("Output changed while stalled.");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[4:0] <= 5'(K_END)) && (m_axis_tdata[39:37] == 3'b000))
		else $error("Token kind out of range or padding set.");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[4:0] == 5'(K_END)) |->
			m_axis_tlast && (m_axis_tdata[36:21] == 16'd0))
		else $error("END token is not last or has nonzero length.");

	a_line: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[20:5] != 16'd0))
		else $error("Token start line is zero.");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[4:0] != 5'(K_END)) && (m_axis_tdata[4:0] != 5'(K_COMMENT)) |->
			(m_axis_tdata[36:21] != 16'd0))
		else $error("Non-comment token has zero length.");

endmodule

bind datalog_token_lexer_unit dtl_checker u_dtl_checker (.*);

>>> dv/datalog_token_lexer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Datalog token lexer testbench
// Streams source text into the lexer one character per transfer, predicts the
// token stream in step with each accepted character, and checks every output
// token field by field. Phases alternate keep_comments, and one phase runs
// both sides without gaps.
// ----------------------------------------------------------------------------
module datalog_token_lexer_unit_tb;

	import dtl_pkg::*;

	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASE_CHARS   = 450;

	typedef enum logic [2:0] {
		LX_IDLE, LX_NAME, LX_COLON, LX_QUOTE, LX_HASH, LX_LINE, LX_BLOCK
	} lex_mode_t;

	typedef struct packed {
		char_t ch;
		logic  eot;
	} char_item_t;

	typedef struct {
		kind_t kind;
		line_t line;
		len_t  len;
		bit    last;
	} token_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;

	char_item_t  pending_chars[$];
	token_t      expected_tokens[$];
	token_t      burst_tokens[$];
	int unsigned chars_queued = 0;
	int unsigned chars_accepted = 0;
	int unsigned tokens_seen = 0;
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	bit [31:0]   kinds_seen = '0;
	bit          steady = 1'b0;

	string kw_words[4] = '{"Schemes", "Facts", "Rules", "Queries"};
	kind_t kw_kinds[4] = '{K_SCHEMES, K_FACTS, K_RULES, K_QUERIES};

	bit        keep_notes = 1'b0;
	lex_mode_t lx_mode = LX_IDLE;
	line_t     lx_line = 1;
	line_t     lx_tok_line = 1;
	len_t      lx_len = 0;
	bit [3:0]  lx_kw = 4'hF;
	bit        lx_lookahead = 1'b0;

	datalog_token_lexer_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Token prediction.

	function void clear_lexer();
		lx_mode = LX_IDLE;
		lx_line = 1;
		lx_tok_line = 1;
		lx_len = 0;
		lx_kw = 4'hF;
		lx_lookahead = 1'b0;
	endfunction

	function void add_token(kind_t kind, line_t line, len_t len);
		burst_tokens.insert(burst_tokens.size(),
		                    '{kind: kind, line: line, len: len, last: 1'b0});
	endfunction

	function void add_note();
		if (keep_notes)
			add_token(K_COMMENT, lx_tok_line, lx_len);
	endfunction

	function void bump_line();
		if (lx_line != '1)
			lx_line++;
	endfunction

	function void grow_len();
		if (lx_len < MAX_TOKEN_LENGTH)
			lx_len++;
	endfunction

	function automatic bit is_letter(char_t c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_alnum(char_t c);
		return is_letter(c) || (c >= "0" && c <= "9");
	endfunction

	function void narrow_keywords(char_t c);
		for (int k = 0; k < 4; k++) begin
			if (!(lx_len < kw_words[k].len() && char_t'(kw_words[k][lx_len]) == c))
				lx_kw[k] = 1'b0;
		end
	endfunction

	function void finish_name();
		kind_t kind;
		kind = K_ID;
		for (int k = 3; k >= 0; k--) begin
			if (lx_kw[k] && lx_len == kw_words[k].len())
				kind = kw_kinds[k];
		end
		add_token(kind, lx_tok_line, lx_len);
	endfunction

	function void open_token(lex_mode_t mode);
		lx_mode = mode;
		lx_tok_line = lx_line;
		lx_len = 1;
		lx_lookahead = 1'b0;
	endfunction

	function void begin_char(char_t c);
		lx_mode = LX_IDLE;
		if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
			if (c == "\n")
				bump_line();
			return;
		end
		case (c)
			",": add_token(K_COMMA, lx_line, 1);
			".": add_token(K_PERIOD, lx_line, 1);
			"?": add_token(K_QMARK, lx_line, 1);
			"(": add_token(K_LPAREN, lx_line, 1);
			")": add_token(K_RPAREN, lx_line, 1);
			"*": add_token(K_MUL, lx_line, 1);
			"+": add_token(K_ADD, lx_line, 1);
			":": open_token(LX_COLON);
			"'": open_token(LX_QUOTE);
			"#": open_token(LX_HASH);
			default: begin
				if (is_letter(c)) begin
					lx_tok_line = lx_line;
					lx_len = 0;
					lx_kw = 4'hF;
					narrow_keywords(c);
					lx_len = 1;
					lx_mode = LX_NAME;
				end else begin
					add_token(K_UNDEF, lx_line, 1);
				end
			end
		endcase
	endfunction

	function void lex_char(char_t c);
		case (lx_mode)
			LX_NAME: begin
				if (is_alnum(c)) begin
					narrow_keywords(c);
					grow_len();
				end else begin
					finish_name();
					begin_char(c);
				end
			end
			LX_COLON: begin
				if (c == "-") begin
					add_token(K_COLONDASH, lx_tok_line, 2);
					lx_mode = LX_IDLE;
				end else begin
					add_token(K_COLON, lx_tok_line, 1);
					begin_char(c);
				end
			end
			LX_QUOTE: begin
				if (lx_lookahead) begin
					lx_lookahead = 1'b0;
					if (c == "'") begin
						grow_len();
					end else begin
						add_token(K_STRING, lx_tok_line, lx_len);
						begin_char(c);
					end
				end else begin
					grow_len();
					if (c == "\n")
						bump_line();
					if (c == "'")
						lx_lookahead = 1'b1;
				end
			end
			LX_HASH: begin
				if (c == "|") begin
					grow_len();
					lx_lookahead = 1'b0;
					lx_mode = LX_BLOCK;
				end else if (c == "\n") begin
					add_note();
					bump_line();
					lx_mode = LX_IDLE;
				end else begin
					grow_len();
					lx_mode = LX_LINE;
				end
			end
			LX_LINE: begin
				if (c == "\n") begin
					add_note();
					bump_line();
					lx_mode = LX_IDLE;
				end else begin
					grow_len();
				end
			end
			LX_BLOCK: begin
				grow_len();
				if (c == "\n")
					bump_line();
				if (lx_lookahead && c == "#") begin
					add_note();
					lx_lookahead = 1'b0;
					lx_mode = LX_IDLE;
				end else begin
					lx_lookahead = (c == "|");
				end
			end
			default: begin_char(c);
		endcase
	endfunction

	function void flush_at_end();
		case (lx_mode)
			LX_NAME:  finish_name();
			LX_COLON: add_token(K_COLON, lx_tok_line, 1);
			LX_QUOTE: add_token(lx_lookahead ? K_STRING : K_UNDEF, lx_tok_line, lx_len);
			LX_HASH, LX_LINE: add_note();
			LX_BLOCK: add_token(K_UNDEF, lx_tok_line, lx_len);
			default: ;
		endcase
		add_token(K_END, lx_line, 0);
		clear_lexer();
	endfunction

	function void predict_tokens(char_t c, logic eot);
		burst_tokens.delete();
		if (eot)
			flush_at_end();
		else
			lex_char(c);
		if (burst_tokens.size() != 0)
			burst_tokens[burst_tokens.size() - 1].last = 1'b1;
		foreach (burst_tokens[i])
			expected_tokens.insert(expected_tokens.size(), burst_tokens[i]);
	endfunction

	// Source text generation.

	function void put_char(char_t c);
		pending_chars.insert(pending_chars.size(), '{ch: c, eot: 1'b0});
		chars_queued++;
	endfunction

	function void put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put_char(char_t'(s[i]));
	endfunction

	function void put_end();
		pending_chars.insert(pending_chars.size(),
		                     '{ch: char_t'($urandom_range(255)), eot: 1'b1});
		chars_queued++;
	endfunction

	function automatic char_t any_alnum();
		int unsigned r;
		r = $urandom_range(61);
		if (r < 26)
			return char_t'("a" + r);
		if (r < 52)
			return char_t'("A" + r - 26);
		return char_t'("0" + r - 52);
	endfunction

	function void queue_random_text(int unsigned count);
		int unsigned goal;
		int unsigned roll;
		int unsigned n;
		int unsigned pick;
		string       word;
		string       punct;
		string       inner;
		goal = chars_queued + count;
		punct = ",.?()*+:";
		inner = "ab|# \n";
		while (chars_queued < goal) begin
			roll = $urandom_range(99);
			n = $urandom_range(6);
			if (roll < 12) begin
				word = kw_words[$urandom_range(3)];
				pick = $urandom_range(3);
				if (pick == 0) begin
					put_text(word.substr(0, word.len() - 2));
				end else begin
					put_text(word);
					if (pick == 1)
						put_char(any_alnum());
				end
			end else if (roll < 28) begin
				put_char(is_letter(any_alnum()) ? "q" : "Z");
				repeat (n) put_char(any_alnum());
			end else if (roll < 38) begin
				put_char("'");
				repeat (n) begin
					pick = $urandom_range(9);
					if (pick == 0)
						put_text("''");
					else if (pick == 1)
						put_char("\n");
					else
						put_char(char_t'($urandom_range(126, 32)));
				end
				put_char("'");
			end else if (roll < 58) begin
				if ($urandom_range(3) == 0)
					put_text(":-");
				else
					put_char(char_t'(punct[$urandom_range(7)]));
			end else if (roll < 73) begin
				repeat (n % 3 + 1) begin
					pick = $urandom_range(7);
					put_char(pick == 0 ? 8'd32 : pick > 5 ? 8'd10 : char_t'(pick + 8));
				end
			end else if (roll < 80) begin
				put_char("#");
				repeat (n) begin
					pick = $urandom_range(255);
					put_char(pick == 10 ? 8'd32 : char_t'(pick));
				end
				put_char("\n");
			end else if (roll < 87) begin
				put_text("#|");
				repeat (n) put_char(char_t'(inner[$urandom_range(5)]));
				put_text("|#");
			end else if (roll < 94) begin
				repeat (n % 3 + 1) put_char(char_t'($urandom_range(255)));
			end else if (roll < 97) begin
				put_end();
			end else begin
				case ($urandom_range(4))
					0: put_text("'ab");
					1: put_text("#|x|");
					2: put_text("#x");
					3: put_char(":");
					default: put_text("'ab'");
				endcase
				put_end();
			end
		end
		put_end();
	endfunction

	// Stimulus and checking.

	task automatic report_mismatch(string what, longint got, longint want);
		if (mismatches < 40)
			$display("token %0d: %s is %0d, expected %0d", tokens_seen, what, got, want);
		mismatches++;
	endtask

	task automatic write_keep(bit value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		keep_notes = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic drain_and_settle();
		while (chars_accepted != chars_queued || expected_tokens.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin : drive_chars
		char_item_t nxt;
		bit         give;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_tokens(s_axis_tdata, s_axis_tlast);
				chars_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				give = pending_chars.size() != 0 && (steady || $urandom_range(99) >= 26);
				if (give) begin
					nxt = pending_chars.pop_front();
					s_axis_tdata <= nxt.ch;
					s_axis_tlast <= nxt.eot;
				end
				s_axis_tvalid <= give;
			end
		end
	end

	always @(posedge clk) begin : check_tokens
		token_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				tokens_seen++;
				kinds_seen[m_axis_tdata[4:0]] = 1'b1;
				if (expected_tokens.size() == 0) begin
					report_mismatch("transfer with nothing expected, kind", m_axis_tdata[4:0], 0);
				end else begin
					want = expected_tokens.pop_front();
					if (m_axis_tdata[4:0] !== want.kind)
						report_mismatch("token_kind", m_axis_tdata[4:0], want.kind);
					if (m_axis_tdata[20:5] !== want.line)
						report_mismatch("start_line", m_axis_tdata[20:5], want.line);
					if (m_axis_tdata[36:21] !== want.len)
						report_mismatch("text_length", m_axis_tdata[36:21], want.len);
					if (m_axis_tlast !== want.last)
						report_mismatch("last_of_run", m_axis_tlast, want.last);
				end
			end
			m_axis_tready <= steady || $urandom_range(99) >= 26;
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			    (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == QUIET_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
				$display("datalog_token_lexer_unit regression: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		write_keep(1'b0);
		put_text("a:-('a'''),.?*+:");
		put_char(8'hFF);
		put_char(8'h00);
		put_text("#|#|#\n#");
		put_end();
		queue_random_text(PHASE_CHARS);
		drain_and_settle();

		write_keep(1'b1);
		queue_random_text(PHASE_CHARS);
		drain_and_settle();

		write_keep(1'b0);
		queue_random_text(PHASE_CHARS);
		drain_and_settle();

		// Both sides run without gaps for this whole phase.
		steady <= 1'b1;
		write_keep(1'b1);
		queue_random_text(PHASE_CHARS);
		drain_and_settle();
		steady <= 1'b0;

		if (expected_tokens.size() != 0)
			report_mismatch("tokens still expected at end", 0, expected_tokens.size());
		$display("Run covered %0d characters and end marks under both keep_comments settings,",
		         chars_accepted);
		$display("with one gap-free phase; %0d tokens checked, %0d of 18 kinds seen.",
		         tokens_seen, $countones(kinds_seen));
		if (mismatches == 0)
			$display("datalog_token_lexer_unit regression: pass");
		else
			$display("datalog_token_lexer_unit regression: fail");
		$finish;
	end

endmodule
